/* design/seg2d_pkg.sv */
// ---------------------------------------------------------------------------
// seg2d_pkg
// Shared types and constants for the 2D segment intersection pipeline.
// ---------------------------------------------------------------------------
package seg2d_pkg;

  typedef enum logic [1:0] {
    KIND_DISJOINT = 2'd0,
    KIND_POINT    = 2'd1,
    KIND_OVERLAP  = 2'd2,
    KIND_OUTSIDE  = 2'd3
  } kind_t;

  // width of the parallel threshold register and its reset value
  localparam int THR_BITS = 51;
  localparam logic [THR_BITS-1:0] THR_RESET = 51'd1;

  // quotient bits produced by the divider; quotients at or above QCAP are capped
  localparam int QBITS = 41;
  localparam logic [QBITS-1:0] QCAP = 41'h100_0000_0000;

  localparam int OUT_BITS = 32;
  localparam int LANES    = 4;

endpackage

/* design/segment_intersection_2d.sv */
// ---------------------------------------------------------------------------
// segment_intersection_2d
// Classifies two 2D segments p1-p2 and p3-p4 and returns the intersection.
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid / in_stall) carries one segment pair per
// beat as eight signed fixed-point coordinates. The result channel
// (out_valid / out_stall) returns one beat per pair: the kind, two points
// and a saturation flag. cfg_wr_en / cfg_wr_data load the parallel
// threshold; write it only while the pipeline is empty.
// From input beat to result beat a pair passes the difference, product, perp product,
// sign, classification, partial product, dividend and divider init stages, 41
// restoring divider stages (one quotient bit per stage, four lanes side by side),
// then a rounding stage and a saturating output stage. Throughput is one pair
// per cycle unless the receiver stalls; the divider chain is fully pipelined.
// Reset clears every stage valid bit and sets the threshold to 1.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module segment_intersection_2d #(
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [seg2d_pkg::THR_BITS-1:0]       cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_BITS-1:0]         in_p1_x,
  input  logic signed [COORD_BITS-1:0]         in_p1_y,
  input  logic signed [COORD_BITS-1:0]         in_p2_x,
  input  logic signed [COORD_BITS-1:0]         in_p2_y,
  input  logic signed [COORD_BITS-1:0]         in_p3_x,
  input  logic signed [COORD_BITS-1:0]         in_p3_y,
  input  logic signed [COORD_BITS-1:0]         in_p4_x,
  input  logic signed [COORD_BITS-1:0]         in_p4_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_kind,
  output logic signed [seg2d_pkg::OUT_BITS-1:0] out_ix0,
  output logic signed [seg2d_pkg::OUT_BITS-1:0] out_iy0,
  output logic signed [seg2d_pkg::OUT_BITS-1:0] out_ix1,
  output logic signed [seg2d_pkg::OUT_BITS-1:0] out_iy1,
  output logic                                 out_clipped
);

  localparam int CB  = COORD_BITS;
  localparam int DW  = CB + 1;             // coordinate difference
  localparam int PRW = 2 * DW;             // one product of differences
  localparam int PW  = PRW + 1;            // perp product
  localparam int NW  = DW + 1;             // collinear parameter after negation
  localparam int H   = (PW + 1) / 2;       // split point of the wide multiply
  localparam int PLW = DW + H;
  localparam int PHW = DW + PW - H;
  localparam int QB  = seg2d_pkg::QBITS;
  localparam int EW  = PW + QB;            // dividend
  localparam int SQW = QB + 1;             // signed quotient
  localparam int SW  = QB + 2;             // base plus quotient
  localparam int TB  = seg2d_pkg::THR_BITS;
  localparam int CW  = (PW > TB) ? PW : TB;
  localparam int OB  = seg2d_pkg::OUT_BITS;
  localparam int NL  = seg2d_pkg::LANES;

  typedef struct packed {
    logic                 neg;
    logic                 big;
    logic signed [CB-1:0] base;
    logic [PW-1:0]        den;
    logic [PW-1:0]        rem;
    logic [QB-1:0]        lo;
  } div_lane_t;

  // one restoring step: bring down the next dividend bit, shift in a quotient bit
  function automatic div_lane_t div_step(input div_lane_t s);
    logic [PW:0] r2;
    logic        ge;
    div_lane_t   o;
    r2    = {s.rem, s.lo[QB-1]};
    ge    = (r2 >= {1'b0, s.den});
    o     = s;
    o.rem = ge ? PW'(r2 - {1'b0, s.den}) : PW'(r2);
    o.lo  = {s.lo[QB-2:0], ge};
    return o;
  endfunction

  function automatic logic on_seg(input logic signed [CB-1:0] px, input logic signed [CB-1:0] py,
                                  input logic signed [CB-1:0] ax, input logic signed [CB-1:0] ay,
                                  input logic signed [CB-1:0] bx, input logic signed [CB-1:0] by);
    logic res;
    if (ax != bx) begin
      res = (ax <= px && px <= bx) || (ax >= px && px >= bx);
    end else begin
      res = (ay <= py && py <= by) || (ay >= py && py >= by);
    end
    return res;
  endfunction

  logic adv;
  logic [TB-1:0] thr_r;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= seg2d_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // ---------------- stage 1: differences ----------------
  logic                 s1_v_r;
  logic signed [CB-1:0] s1_x1_r, s1_y1_r, s1_x2_r, s1_y2_r, s1_x3_r, s1_y3_r, s1_x4_r, s1_y4_r;
  logic signed [DW-1:0] s1_ux_r, s1_uy_r, s1_vx_r, s1_vy_r, s1_wx_r, s1_wy_r, s1_bx_r, s1_by_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x1_r <= in_p1_x;
      s1_y1_r <= in_p1_y;
      s1_x2_r <= in_p2_x;
      s1_y2_r <= in_p2_y;
      s1_x3_r <= in_p3_x;
      s1_y3_r <= in_p3_y;
      s1_x4_r <= in_p4_x;
      s1_y4_r <= in_p4_y;
      s1_ux_r <= DW'(in_p2_x) - DW'(in_p1_x);
      s1_uy_r <= DW'(in_p2_y) - DW'(in_p1_y);
      s1_vx_r <= DW'(in_p4_x) - DW'(in_p3_x);
      s1_vy_r <= DW'(in_p4_y) - DW'(in_p3_y);
      s1_wx_r <= DW'(in_p1_x) - DW'(in_p3_x);
      s1_wy_r <= DW'(in_p1_y) - DW'(in_p3_y);
      s1_bx_r <= DW'(in_p2_x) - DW'(in_p3_x);
      s1_by_r <= DW'(in_p2_y) - DW'(in_p3_y);
    end
  end

  // ---------------- stage 2: products ----------------
  logic                  s2_v_r;
  logic signed [CB-1:0]  s2_x1_r, s2_y1_r, s2_x2_r, s2_y2_r, s2_x3_r, s2_y3_r, s2_x4_r, s2_y4_r;
  logic signed [DW-1:0]  s2_ux_r, s2_uy_r, s2_vx_r, s2_vy_r, s2_wx_r, s2_wy_r, s2_bx_r, s2_by_r;
  logic signed [PRW-1:0] s2_m0_r, s2_m1_r, s2_m2_r, s2_m3_r, s2_m4_r, s2_m5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x1_r <= s1_x1_r;
      s2_y1_r <= s1_y1_r;
      s2_x2_r <= s1_x2_r;
      s2_y2_r <= s1_y2_r;
      s2_x3_r <= s1_x3_r;
      s2_y3_r <= s1_y3_r;
      s2_x4_r <= s1_x4_r;
      s2_y4_r <= s1_y4_r;
      s2_ux_r <= s1_ux_r;
      s2_uy_r <= s1_uy_r;
      s2_vx_r <= s1_vx_r;
      s2_vy_r <= s1_vy_r;
      s2_wx_r <= s1_wx_r;
      s2_wy_r <= s1_wy_r;
      s2_bx_r <= s1_bx_r;
      s2_by_r <= s1_by_r;
      s2_m0_r <= s1_ux_r * s1_vy_r;
      s2_m1_r <= s1_uy_r * s1_vx_r;
      s2_m2_r <= s1_ux_r * s1_wy_r;
      s2_m3_r <= s1_uy_r * s1_wx_r;
      s2_m4_r <= s1_vx_r * s1_wy_r;
      s2_m5_r <= s1_vy_r * s1_wx_r;
    end
  end

  // ---------------- stage 3: perp products ----------------
  logic                 s3_v_r;
  logic signed [CB-1:0] s3_x1_r, s3_y1_r, s3_x2_r, s3_y2_r, s3_x3_r, s3_y3_r, s3_x4_r, s3_y4_r;
  logic signed [DW-1:0] s3_ux_r, s3_uy_r, s3_vx_r, s3_vy_r, s3_wx_r, s3_wy_r, s3_bx_r, s3_by_r;
  logic signed [PW-1:0] s3_d_r, s3_puw_r, s3_pvw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_x1_r  <= s2_x1_r;
      s3_y1_r  <= s2_y1_r;
      s3_x2_r  <= s2_x2_r;
      s3_y2_r  <= s2_y2_r;
      s3_x3_r  <= s2_x3_r;
      s3_y3_r  <= s2_y3_r;
      s3_x4_r  <= s2_x4_r;
      s3_y4_r  <= s2_y4_r;
      s3_ux_r  <= s2_ux_r;
      s3_uy_r  <= s2_uy_r;
      s3_vx_r  <= s2_vx_r;
      s3_vy_r  <= s2_vy_r;
      s3_wx_r  <= s2_wx_r;
      s3_wy_r  <= s2_wy_r;
      s3_bx_r  <= s2_bx_r;
      s3_by_r  <= s2_by_r;
      s3_d_r   <= PW'(s2_m0_r) - PW'(s2_m1_r);
      s3_puw_r <= PW'(s2_m2_r) - PW'(s2_m3_r);
      s3_pvw_r <= PW'(s2_m4_r) - PW'(s2_m5_r);
    end
  end

  // ---------------- stage 4: signs, magnitudes, point tests ----------------
  logic                 s4_v_r;
  logic                 s4_dz_r, s4_cz_r, s4_upt_r, s4_vpt_r, s4_eqp_r, s4_on1_r, s4_on3_r;
  logic [PW-1:0]        s4_dmag_r;
  logic signed [PW-1:0] s4_n0_r, s4_n1_r;
  logic signed [NW-1:0] s4_cden_r, s4_ca_r, s4_cb_r;
  logic [DW-1:0]        s4_mux_r, s4_muy_r, s4_mvx_r, s4_mvy_r;
  logic                 s4_sux_r, s4_suy_r, s4_svx_r, s4_svy_r;
  logic signed [CB-1:0] s4_x1_r, s4_y1_r, s4_x3_r, s4_y3_r;
  logic signed [NW-1:0] c_den, c_a, c_b;

  // collinear case: parameterize along the x axis of v when it is nonzero, else along y
  always_comb begin
    if (s3_vx_r != '0) begin
      c_den = NW'(s3_vx_r);
      c_a   = NW'(s3_wx_r);
      c_b   = NW'(s3_bx_r);
    end else begin
      c_den = NW'(s3_vy_r);
      c_a   = NW'(s3_wy_r);
      c_b   = NW'(s3_by_r);
    end
    if (c_den < 0) begin
      c_den = -c_den;
      c_a   = -c_a;
      c_b   = -c_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_dz_r   <= (s3_d_r == '0);
      s4_dmag_r <= s3_d_r[PW-1] ? PW'(-s3_d_r) : PW'(s3_d_r);
      s4_n0_r   <= s3_d_r[PW-1] ? -s3_pvw_r : s3_pvw_r;
      s4_n1_r   <= s3_d_r[PW-1] ? -s3_puw_r : s3_puw_r;
      s4_cz_r   <= (s3_puw_r == '0) && (s3_pvw_r == '0);
      s4_upt_r  <= (s3_ux_r == '0) && (s3_uy_r == '0);
      s4_vpt_r  <= (s3_vx_r == '0) && (s3_vy_r == '0);
      s4_eqp_r  <= (s3_x1_r == s3_x3_r) && (s3_y1_r == s3_y3_r);
      s4_on1_r  <= on_seg(s3_x1_r, s3_y1_r, s3_x3_r, s3_y3_r, s3_x4_r, s3_y4_r);
      s4_on3_r  <= on_seg(s3_x3_r, s3_y3_r, s3_x1_r, s3_y1_r, s3_x2_r, s3_y2_r);
      s4_cden_r <= c_den;
      s4_ca_r   <= c_a;
      s4_cb_r   <= c_b;
      s4_mux_r  <= s3_ux_r[DW-1] ? DW'(-s3_ux_r) : DW'(s3_ux_r);
      s4_muy_r  <= s3_uy_r[DW-1] ? DW'(-s3_uy_r) : DW'(s3_uy_r);
      s4_mvx_r  <= s3_vx_r[DW-1] ? DW'(-s3_vx_r) : DW'(s3_vx_r);
      s4_mvy_r  <= s3_vy_r[DW-1] ? DW'(-s3_vy_r) : DW'(s3_vy_r);
      s4_sux_r  <= s3_ux_r[DW-1];
      s4_suy_r  <= s3_uy_r[DW-1];
      s4_svx_r  <= s3_vx_r[DW-1];
      s4_svy_r  <= s3_vy_r[DW-1];
      s4_x1_r   <= s3_x1_r;
      s4_y1_r   <= s3_y1_r;
      s4_x3_r   <= s3_x3_r;
      s4_y3_r   <= s3_y3_r;
    end
  end

  // ---------------- stage 5: classification and lane setup ----------------
  logic                 s5_v_r;
  seg2d_pkg::kind_t     s5_kind_r;
  logic signed [CB-1:0] s5_base_r [NL];
  logic [DW-1:0]        s5_cm_r   [NL];
  logic [PW-1:0]        s5_num_r  [NL];
  logic [PW-1:0]        s5_den_r  [NL];
  logic                 s5_neg_r  [NL];

  seg2d_pkg::kind_t     k5;
  logic signed [CB-1:0] base5 [NL];
  logic [DW-1:0]        cm5   [NL];
  logic [PW-1:0]        num5  [NL];
  logic [PW-1:0]        den5  [NL];
  logic                 neg5  [NL];
  logic                 par5, hit5, out5;
  logic signed [NW-1:0] sa5, sb5, ac5, bc5;
  logic [PW-1:0]        n0m5;

  always_comb begin
    par5 = s4_dz_r || (CW'(s4_dmag_r) < CW'(thr_r));
    sa5  = (s4_ca_r > s4_cb_r) ? s4_cb_r : s4_ca_r;
    sb5  = (s4_ca_r > s4_cb_r) ? s4_ca_r : s4_cb_r;
    hit5 = !(sa5 > s4_cden_r || sb5 < 0);
    ac5  = (sa5 < 0) ? '0 : sa5;
    bc5  = (sb5 > s4_cden_r) ? s4_cden_r : sb5;
    out5 = (s4_n0_r < 0) || (s4_n0_r > $signed(s4_dmag_r)) ||
           (s4_n1_r < 0) || (s4_n1_r > $signed(s4_dmag_r));
    n0m5 = s4_n0_r[PW-1] ? PW'(-s4_n0_r) : PW'(s4_n0_r);
    k5   = seg2d_pkg::KIND_DISJOINT;
    for (int l = 0; l < NL; l++) begin
      base5[l] = '0;
      cm5[l]   = '0;
      num5[l]  = '0;
      den5[l]  = PW'(1);
      neg5[l]  = 1'b0;
    end
    if (par5) begin
      if (!s4_cz_r) begin
        k5 = seg2d_pkg::KIND_DISJOINT;
      end else if (s4_upt_r && s4_vpt_r) begin
        if (s4_eqp_r) begin
          k5 = seg2d_pkg::KIND_POINT;
          base5[0] = s4_x1_r;
          base5[1] = s4_y1_r;
        end
      end else if (s4_upt_r) begin
        if (s4_on1_r) begin
          k5 = seg2d_pkg::KIND_POINT;
          base5[0] = s4_x1_r;
          base5[1] = s4_y1_r;
        end
      end else if (s4_vpt_r) begin
        if (s4_on3_r) begin
          k5 = seg2d_pkg::KIND_POINT;
          base5[0] = s4_x3_r;
          base5[1] = s4_y3_r;
        end
      end else if (hit5) begin
        // overlap clipped to the second segment, endpoints along v
        base5[0] = s4_x3_r;
        base5[1] = s4_y3_r;
        cm5[0]   = s4_mvx_r;
        cm5[1]   = s4_mvy_r;
        num5[0]  = PW'(ac5);
        num5[1]  = PW'(ac5);
        den5[0]  = PW'(s4_cden_r);
        den5[1]  = PW'(s4_cden_r);
        neg5[0]  = s4_svx_r;
        neg5[1]  = s4_svy_r;
        if (ac5 == bc5) begin
          k5 = seg2d_pkg::KIND_POINT;
        end else begin
          k5 = seg2d_pkg::KIND_OVERLAP;
          base5[2] = s4_x3_r;
          base5[3] = s4_y3_r;
          cm5[2]   = s4_mvx_r;
          cm5[3]   = s4_mvy_r;
          num5[2]  = PW'(bc5);
          num5[3]  = PW'(bc5);
          den5[2]  = PW'(s4_cden_r);
          den5[3]  = PW'(s4_cden_r);
          neg5[2]  = s4_svx_r;
          neg5[3]  = s4_svy_r;
        end
      end
    end else begin
      k5 = out5 ? seg2d_pkg::KIND_OUTSIDE : seg2d_pkg::KIND_POINT;
      base5[0] = s4_x1_r;
      base5[1] = s4_y1_r;
      cm5[0]   = s4_mux_r;
      cm5[1]   = s4_muy_r;
      num5[0]  = n0m5;
      num5[1]  = n0m5;
      den5[0]  = s4_dmag_r;
      den5[1]  = s4_dmag_r;
      neg5[0]  = s4_sux_r ^ s4_n0_r[PW-1];
      neg5[1]  = s4_suy_r ^ s4_n0_r[PW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_kind_r <= k5;
      for (int l = 0; l < NL; l++) begin
        s5_base_r[l] <= base5[l];
        s5_cm_r[l]   <= cm5[l];
        s5_num_r[l]  <= num5[l];
        s5_den_r[l]  <= den5[l];
        s5_neg_r[l]  <= neg5[l];
      end
    end
  end

  // ---------------- stage 6: partial products ----------------
  logic                 s6_v_r;
  seg2d_pkg::kind_t     s6_kind_r;
  logic signed [CB-1:0] s6_base_r [NL];
  logic [PLW-1:0]       s6_pl_r   [NL];
  logic [PHW-1:0]       s6_ph_r   [NL];
  logic [PW-1:0]        s6_den_r  [NL];
  logic                 s6_neg_r  [NL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_kind_r <= s5_kind_r;
      for (int l = 0; l < NL; l++) begin
        s6_base_r[l] <= s5_base_r[l];
        s6_pl_r[l]   <= PLW'(s5_cm_r[l]) * PLW'(s5_num_r[l][H-1:0]);
        s6_ph_r[l]   <= PHW'(s5_cm_r[l]) * PHW'(s5_num_r[l][PW-1:H]);
        s6_den_r[l]  <= s5_den_r[l];
        s6_neg_r[l]  <= s5_neg_r[l];
      end
    end
  end

  // ---------------- stage 7: dividend ----------------
  logic                 s7_v_r;
  seg2d_pkg::kind_t     s7_kind_r;
  logic signed [CB-1:0] s7_base_r [NL];
  logic [EW-1:0]        s7_p_r    [NL];
  logic [PW-1:0]        s7_den_r  [NL];
  logic                 s7_neg_r  [NL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (adv) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_kind_r <= s6_kind_r;
      for (int l = 0; l < NL; l++) begin
        s7_base_r[l] <= s6_base_r[l];
        s7_p_r[l]    <= EW'(s6_pl_r[l]) + (EW'(s6_ph_r[l]) << H);
        s7_den_r[l]  <= s6_den_r[l];
        s7_neg_r[l]  <= s6_neg_r[l];
      end
    end
  end

  // ---------------- divider: init stage plus one stage per quotient bit ----------------
  div_lane_t        dv_r   [QB+1][NL];
  div_lane_t        dv_nxt [QB+1][NL];
  seg2d_pkg::kind_t dk_r   [QB+1];
  logic             dvld_r [QB+1];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      dv_nxt[0][l].neg  = s7_neg_r[l];
      dv_nxt[0][l].base = s7_base_r[l];
      dv_nxt[0][l].den  = s7_den_r[l];
      dv_nxt[0][l].rem  = s7_p_r[l][EW-1:QB];
      dv_nxt[0][l].lo   = s7_p_r[l][QB-1:0];
      // quotient would reach the cap: saturate instead of dividing
      dv_nxt[0][l].big  = (s7_p_r[l][EW-1:QB-1] >= {1'b0, s7_den_r[l]});
    end
    for (int k = 0; k < QB; k++) begin
      for (int l = 0; l < NL; l++) begin
        dv_nxt[k+1][l] = div_step(dv_r[k][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) begin
        dvld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      dvld_r[0] <= s7_v_r;
      for (int k = 0; k < QB; k++) begin
        dvld_r[k+1] <= dvld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dk_r[0] <= s7_kind_r;
      for (int k = 0; k < QB; k++) begin
        dk_r[k+1] <= dk_r[k];
      end
      for (int k = 0; k <= QB; k++) begin
        for (int l = 0; l < NL; l++) begin
          dv_r[k][l] <= dv_nxt[k][l];
        end
      end
    end
  end

  // ---------------- rounding and sign ----------------
  logic                  fa_v_r;
  seg2d_pkg::kind_t      fa_kind_r;
  logic signed [CB-1:0]  fa_base_r [NL];
  logic signed [SQW-1:0] fa_sq_r   [NL];
  logic [QB-1:0]         q_a       [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (dv_r[QB][l].big) begin
        q_a[l] = seg2d_pkg::QCAP;
      end else begin
        // round half away from zero on the magnitude
        q_a[l] = dv_r[QB][l].lo +
                 QB'({dv_r[QB][l].rem, 1'b0} >= {1'b0, dv_r[QB][l].den});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_v_r <= 1'b0;
    end else if (adv) begin
      fa_v_r <= dvld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fa_kind_r <= dk_r[QB];
      for (int l = 0; l < NL; l++) begin
        fa_base_r[l] <= dv_r[QB][l].base;
        fa_sq_r[l]   <= dv_r[QB][l].neg ? -$signed(SQW'(q_a[l])) : $signed(SQW'(q_a[l]));
      end
    end
  end

  // ---------------- output: add base and saturate ----------------
  logic signed [SW-1:0] sum_b [NL];
  logic signed [OB-1:0] sat_b [NL];
  logic                 clip_b;

  always_comb begin
    clip_b = 1'b0;
    for (int l = 0; l < NL; l++) begin
      sum_b[l] = SW'(fa_base_r[l]) + SW'(fa_sq_r[l]);
      if ((sum_b[l][SW-1:OB-1] == '0) || (sum_b[l][SW-1:OB-1] == '1)) begin
        sat_b[l] = sum_b[l][OB-1:0];
      end else begin
        clip_b   = 1'b1;
        sat_b[l] = sum_b[l][SW-1] ? {1'b1, {(OB-1){1'b0}}} : {1'b0, {(OB-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind    <= fa_kind_r;
      out_ix0     <= sat_b[0];
      out_iy0     <= sat_b[1];
      out_ix1     <= sat_b[2];
      out_iy1     <= sat_b[3];
      out_clipped <= clip_b;
    end
  end

`ifndef NO_ASSERTIONS
  // a disjoint result carries no geometry
  a_disjoint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == seg2d_pkg::KIND_DISJOINT |->
      out_ix0 == '0 && out_iy0 == '0 && out_ix1 == '0 && out_iy1 == '0 && !out_clipped)
    else $error("disjoint result with nonzero fields");

  // second point only for an overlap
  a_second_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != seg2d_pkg::KIND_OVERLAP |-> out_ix1 == '0 && out_iy1 == '0)
    else $error("second point set outside overlap");

  // only a crossing outside the segments can land out of range
  a_clip_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_kind == seg2d_pkg::KIND_OUTSIDE)
    else $error("saturation on a bounded result");
`endif

endmodule

/* dv/tb_segment_intersection_2d.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_segment_intersection_2d
// Drives segment pairs through segment_intersection_2d and checks every
// result beat against an in-bench model of the classification and geometry,
// under several parallel thresholds and with random gaps and stalls.
// ---------------------------------------------------------------------------
module tb_segment_intersection_2d;

  localparam int CB = 24;
  localparam int DRAIN_CYCLES = 60;
  localparam longint QLIM = longint'(1) << 40;
  localparam longint THR_MAX = (longint'(1) << seg2d_pkg::THR_BITS) - 1;

  typedef struct {
    logic signed [CB-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  } seg_pair_t;

  typedef struct {
    seg2d_pkg::kind_t kind;
    logic signed [seg2d_pkg::OUT_BITS-1:0] ix0, iy0, ix1, iy1;
    logic clipped;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [seg2d_pkg::THR_BITS-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] in_p1_x = '0, in_p1_y = '0, in_p2_x = '0, in_p2_y = '0;
  logic signed [CB-1:0] in_p3_x = '0, in_p3_y = '0, in_p4_x = '0, in_p4_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic signed [seg2d_pkg::OUT_BITS-1:0] out_ix0, out_iy0, out_ix1, out_iy1;
  logic out_clipped;

  crossing_t pending_q[$];
  longint threshold_model = 1;
  int errors = 0;
  int burst_left = 0;
  int unsigned cyc = 0;

  segment_intersection_2d #(.COORD_BITS(CB)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_p1_x(in_p1_x), .in_p1_y(in_p1_y), .in_p2_x(in_p2_x), .in_p2_y(in_p2_y),
    .in_p3_x(in_p3_x), .in_p3_y(in_p3_y), .in_p4_x(in_p4_x), .in_p4_y(in_p4_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_ix0(out_ix0), .out_iy0(out_iy0), .out_ix1(out_ix1), .out_iy1(out_iy1),
    .out_clipped(out_clipped)
  );

  always #1 clk = ~clk;

  // ---------------- model ----------------
  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // round(a*n/d), ties away from zero, magnitude capped
  function automatic longint scaled_round(longint a, longint n, longint d);
    logic [127:0] prod, quo, rem;
    longint q;
    prod = 128'(magnitude(a)) * 128'(magnitude(n));
    quo = prod / 128'(d);
    rem = prod % 128'(d);
    if (quo >= 128'(QLIM)) q = QLIM;
    else begin
      q = longint'(quo);
      if (rem >= 128'(d) - rem) q++;
    end
    return ((a < 0) != (n < 0)) ? -q : q;
  endfunction

  function automatic longint sat_coord(longint v, inout logic clip);
    if (v > 64'sd2147483647) begin clip = 1'b1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin clip = 1'b1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic bit on_seg(longint px, longint py, longint ax, longint ay,
                                longint bx, longint by);
    if (ax != bx) return (ax <= px && px <= bx) || (ax >= px && px >= bx);
    return (ay <= py && py <= by) || (ay >= py && py >= by);
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s);
    longint x1, y1, x2, y2, x3, y3, x4, y4, ux, uy, vx, vy, wx, wy;
    longint d, puw, pvw, den, a, b, t, dd, n0, n1;
    longint r[4];
    seg2d_pkg::kind_t k;
    logic clip;
    bit upt, vpt, outside;
    crossing_t c;
    x1 = s.x1; y1 = s.y1; x2 = s.x2; y2 = s.y2;
    x3 = s.x3; y3 = s.y3; x4 = s.x4; y4 = s.y4;
    ux = x2 - x1; uy = y2 - y1; vx = x4 - x3; vy = y4 - y3;
    wx = x1 - x3; wy = y1 - y3;
    d = ux * vy - uy * vx;
    puw = ux * wy - uy * wx;
    pvw = vx * wy - vy * wx;
    r = '{0, 0, 0, 0};
    k = seg2d_pkg::KIND_DISJOINT;
    clip = 1'b0;
    if (d == 0 || magnitude(d) < longint'(threshold_model)) begin
      upt = (ux == 0 && uy == 0);
      vpt = (vx == 0 && vy == 0);
      if (puw != 0 || pvw != 0) begin
        k = seg2d_pkg::KIND_DISJOINT;
      end else if (upt && vpt) begin
        if (x1 == x3 && y1 == y3) begin
          k = seg2d_pkg::KIND_POINT; r[0] = x1; r[1] = y1;
        end
      end else if (upt) begin
        if (on_seg(x1, y1, x3, y3, x4, y4)) begin
          k = seg2d_pkg::KIND_POINT; r[0] = x1; r[1] = y1;
        end
      end else if (vpt) begin
        if (on_seg(x3, y3, x1, y1, x2, y2)) begin
          k = seg2d_pkg::KIND_POINT; r[0] = x3; r[1] = y3;
        end
      end else begin
        if (vx != 0) begin den = vx; a = wx; b = x2 - x3; end
        else begin den = vy; a = wy; b = y2 - y3; end
        if (den < 0) begin den = -den; a = -a; b = -b; end
        if (a > b) begin t = a; a = b; b = t; end
        if (!(a > den || b < 0)) begin
          if (a < 0) a = 0;
          if (b > den) b = den;
          r[0] = x3 + scaled_round(vx, a, den);
          r[1] = y3 + scaled_round(vy, a, den);
          if (a == b) k = seg2d_pkg::KIND_POINT;
          else begin
            k = seg2d_pkg::KIND_OVERLAP;
            r[2] = x3 + scaled_round(vx, b, den);
            r[3] = y3 + scaled_round(vy, b, den);
          end
        end
      end
    end else begin
      dd = d; n0 = pvw; n1 = puw;
      if (dd < 0) begin dd = -dd; n0 = -n0; n1 = -n1; end
      outside = (n0 < 0 || n0 > dd || n1 < 0 || n1 > dd);
      r[0] = sat_coord(x1 + scaled_round(ux, n0, dd), clip);
      r[1] = sat_coord(y1 + scaled_round(uy, n0, dd), clip);
      k = outside ? seg2d_pkg::KIND_OUTSIDE : seg2d_pkg::KIND_POINT;
    end
    for (int j = 0; j < 4; j++) r[j] = sat_coord(r[j], clip);
    c.kind = k;
    c.ix0 = r[0][31:0]; c.iy0 = r[1][31:0];
    c.ix1 = r[2][31:0]; c.iy1 = r[3][31:0];
    c.clipped = clip;
    return c;
  endfunction

  // ---------------- driving ----------------
  task automatic send_pair(seg_pair_t s);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_p1_x <= s.x1; in_p1_y <= s.y1; in_p2_x <= s.x2; in_p2_y <= s.y2;
    in_p3_x <= s.x3; in_p3_y <= s.y3; in_p4_x <= s.x4; in_p4_y <= s.y4;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(predict_crossing(s));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(longint v);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[seg2d_pkg::THR_BITS-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold_model = v;
  endtask

  function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
    seg_pair_t s;
    s.x1 = CB'(a); s.y1 = CB'(b); s.x2 = CB'(c); s.y2 = CB'(d);
    s.x3 = CB'(e); s.y3 = CB'(f); s.x4 = CB'(g); s.y4 = CB'(h);
    return s;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 8388607 : -8388608;
      1: return int'($urandom_range(0, 8191)) - 4096;
      default: return {{8{1'b0}}, 24'($urandom)};
    endcase
  endfunction

  function automatic seg_pair_t random_pair();
    int px, py, dx, dy, k1, k2, k3;
    seg_pair_t s;
    px = int'($urandom_range(0, 2097151)) - 1048576;
    py = int'($urandom_range(0, 2097151)) - 1048576;
    dx = int'($urandom_range(0, 511)) - 256;
    dy = int'($urandom_range(0, 511)) - 256;
    k1 = int'($urandom_range(0, 2047)) - 1024;
    k2 = int'($urandom_range(0, 2047)) - 1024;
    k3 = int'($urandom_range(0, 2047)) - 1024;
    case ($urandom_range(0, 7))
      // collinear pair on one line
      0, 1: s = mk(px, py, px + k1*dx, py + k1*dy, px + k2*dx, py + k2*dy,
                   px + k3*dx, py + k3*dy);
      // one or both segments shrunk to a point, often on the other
      2: begin
        s = mk(px, py, px + k1*dx, py + k1*dy, px + k2*dx, py + k2*dy,
               px + k2*dx, py + k2*dy);
        if ($urandom_range(0, 1)) s = mk(s.x3, s.y3, s.x3, s.y3, s.x1, s.y1, s.x2, s.y2);
        if ($urandom_range(0, 3) == 0) s = mk(px, py, px, py, px + k1, py, px + k1, py);
      end
      // parallel, shifted off the line
      3: s = mk(px, py, px + k1*dx, py + k1*dy, px + k2*dx + 1, py + k2*dy,
                px + k3*dx + 1, py + k3*dy);
      // nearly parallel
      4: s = mk(px, py, px + k1*dx, py + k1*dy, px, py + 3,
                px + k1*dx + $urandom_range(0, 2), py + k1*dy + 3);
      default: s = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endcase
    return s;
  endfunction

  // ---------------- tests ----------------
  task automatic test_extremes();
    send_pair(mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    send_pair(mk(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                 -8388608, -8388608));
    send_pair(mk(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607, 8388607,
                 -8388608));
    send_pair(mk(8388607, -8388608, -8388608, 8388607, -8388608, -8388608, 8388607,
                 8388607));
    // crossing far outside range saturates
    send_pair(mk(-8388608, -8388608, 8388607, -8388607, 0, 8388607, 1, 8388607));
    send_pair(mk(8388607, 8388607, -8388608, 8388606, 0, -8388608, -1, -8388608));
  endtask

  task automatic test_special_cases();
    send_pair(mk(0, 0, 4096, 4096, 0, 4096, 4096, 0));
    send_pair(mk(0, 0, 4096, 0, 8192, -10, 8192, 10));
    send_pair(mk(5, 7, 5, 7, 5, 7, 5, 7));
    send_pair(mk(5, 7, 5, 7, 5, 8, 5, 8));
    send_pair(mk(10, 10, 10, 10, 0, 0, 20, 20));
    send_pair(mk(10, 11, 10, 11, 0, 0, 20, 20));
    send_pair(mk(0, 0, 30, 0, 15, 0, 15, 0));
    send_pair(mk(0, 0, 0, 30, 0, 40, 0, 40));
    send_pair(mk(0, 0, 100, 50, 40, 20, 300, 150));
    send_pair(mk(0, 0, 100, 50, 100, 50, 300, 150));
    send_pair(mk(0, 0, 100, 50, 200, 100, 300, 150));
    send_pair(mk(0, 0, 0, 90, 0, 60, 0, -30));
    send_pair(mk(0, 0, 100, 50, 0, 1, 100, 51));
    send_pair(mk(0, 0, 3, 1, 1, 0, 4, 1));
    set_threshold(0);
    send_pair(mk(0, 0, 100, 50, 0, 1, 100, 51));
    send_pair(mk(0, 0, 3, 1, 1, 0, 4, 1));
    send_pair(mk(0, 0, 3, 1, 0, 0, 3, 1));
  endtask

  task automatic test_random(int count, longint thr);
    set_threshold(thr);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && $urandom_range(0, 1)) drain();
      send_pair(random_pair());
    end
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case ((cyc / 400) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= (cyc % 7 < 3);
      default: out_stall <= $urandom_range(0, 1);
    endcase
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    crossing_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("unexpected result beat");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_kind !== e.kind) report_mismatch("kind", out_kind, e.kind);
        if (out_ix0 !== e.ix0) report_mismatch("ix0", out_ix0, e.ix0);
        if (out_iy0 !== e.iy0) report_mismatch("iy0", out_iy0, e.iy0);
        if (out_ix1 !== e.ix1) report_mismatch("ix1", out_ix1, e.ix1);
        if (out_iy1 !== e.iy1) report_mismatch("iy1", out_iy1, e.iy1);
        if (out_clipped !== e.clipped) report_mismatch("clipped", out_clipped, e.clipped);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    test_random(200, 1);
    test_random(200, 0);
    test_random(150, longint'($urandom_range(1, 1 << 30)) << 10);
    test_random(100, THR_MAX);
    test_random(150, 1);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
